[rtl/esc_pkg.sv]
// esc_pkg: constants, reciprocal factors and small helper functions for the
// epoch-seconds-to-calendar pipeline
// no dependencies
package esc_pkg;

  typedef struct packed {
    logic load0;
    logic load1;
    logic load2;
    logic load3;
    logic load_out;
  } esc_load_t;

  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;

  // secs / 86400 = (secs >> 7) / 675
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam int          DAY_SHIFT     = 35;
  localparam logic [9:0]  DAY_DIV_LOW   = 10'd675;

  localparam logic [16:0] WEEK_RECIP    = 17'd74899;
  localparam int          WEEK_SHIFT    = 19;

  // estimate of the year index, days / 365, one too high at most
  localparam logic [15:0] YEAR_RECIP    = 16'd45965;
  localparam int          YEAR_SHIFT    = 24;

  // x / 60 = (x >> 2) / 15
  localparam logic [15:0] MIN_RECIP     = 16'd34953;
  localparam int          MIN_SHIFT     = 19;
  localparam logic [9:0]  HOUR_RECIP    = 10'd547;
  localparam int          HOUR_SHIFT    = 13;

  // year 2100 is the only century year in range that is not a leap year
  localparam logic [7:0]  CENTURY_IDX   = 8'd130;

  // first day number of a year, counted from 1970-01-01
  function automatic logic [15:0] year_start(input logic [7:0] idx);
    logic [15:0] base;
    logic [15:0] leaps;
    base  = 16'(idx) * 16'd365;
    leaps = 16'((9'(idx) + 9'd1) >> 2);
    if (idx > CENTURY_IDX) begin
      leaps = leaps - 16'd1;
    end
    return base + leaps;
  endfunction

  function automatic logic is_leap(input logic [7:0] idx);
    return (idx[1:0] == 2'd2) && (idx != CENTURY_IDX);
  endfunction

  // first day of year of a month, month index 0 is january
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[rtl/esc_day_split.sv]
// esc_day_split: input register and split of the seconds count into whole
// days and seconds of the day; uses esc_pkg
module esc_day_split (
  input  logic              clk_i,
  input  esc_pkg::esc_load_t load_i,
  input  logic [31:0]       epoch_seconds_i,
  output logic [15:0]       days_o,
  output logic [16:0]       tod_o
);
  import esc_pkg::*;

  logic [31:0] secs_q;
  logic [15:0] days_q, days_d;
  logic [16:0] tod_q, tod_d;
  logic [24:0] s7;
  logic [50:0] day_prod;
  logic [25:0] back_prod;
  logic [24:0] rem;

  always_comb begin
    s7        = secs_q[31:7];
    day_prod  = 51'(s7) * 51'(DAY_RECIP);
    days_d    = day_prod[DAY_SHIFT+15:DAY_SHIFT];
    back_prod = 26'(days_d) * 26'(DAY_DIV_LOW);
    rem       = s7 - back_prod[24:0];
    tod_d     = {rem[9:0], secs_q[6:0]};
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load0) begin
      secs_q <= epoch_seconds_i;
    end
    if (load_i.load1) begin
      days_q <= days_d;
      tod_q  <= tod_d;
    end
  end

  assign days_o = days_q;
  assign tod_o  = tod_q;

endmodule

[rtl/esc_year_find.sv]
// esc_year_find: weekday, year estimate and its correction, day of year
// uses esc_pkg
module esc_year_find (
  input  logic              clk_i,
  input  esc_pkg::esc_load_t load_i,
  input  logic [15:0]       days_i,
  output logic [11:0]       year_o,
  output logic              leap_o,
  output logic [8:0]        rest_o,
  output logic [2:0]        weekday_o
);
  import esc_pkg::*;

  logic [15:0] days2_q;
  logic [7:0]  est_q, est_d;
  logic [2:0]  wd2_q, wd2_d;
  logic [11:0] year_q, year_d;
  logic        leap_q, leap_d;
  logic [8:0]  rest_q, rest_d;
  logic [2:0]  wd3_q;

  logic [15:0] wk_x;
  logic [31:0] wk_prod;
  logic [12:0] wk_q;
  logic [15:0] wk_rem;
  logic [31:0] est_prod;
  logic [7:0]  est_m1;
  logic [15:0] start_e, start_p, start_sel;
  logic        below;
  logic [7:0]  idx;
  logic [15:0] rest_full;

  // stage b: weekday and year estimate
  always_comb begin
    wk_x     = days_i + 16'(EPOCH_WEEKDAY);
    wk_prod  = 32'(wk_x) * 32'(WEEK_RECIP);
    wk_q     = wk_prod[WEEK_SHIFT+12:WEEK_SHIFT];
    wk_rem   = wk_x - 16'(wk_q) * 16'd7;
    wd2_d    = wk_rem[2:0];
    est_prod = 32'(days_i) * 32'(YEAR_RECIP);
    est_d    = est_prod[YEAR_SHIFT+7:YEAR_SHIFT];
  end

  // stage c: step back one year when the estimate overshoots
  always_comb begin
    est_m1    = est_q - 8'd1;
    start_e   = year_start(est_q);
    start_p   = year_start(est_m1);
    below     = days2_q < start_e;
    idx       = below ? est_m1 : est_q;
    start_sel = below ? start_p : start_e;
    rest_full = days2_q - start_sel;
    rest_d    = rest_full[8:0];
    year_d    = EPOCH_YEAR + 12'(idx);
    leap_d    = is_leap(idx);
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load2) begin
      days2_q <= days_i;
      est_q   <= est_d;
      wd2_q   <= wd2_d;
    end
    if (load_i.load3) begin
      year_q <= year_d;
      leap_q <= leap_d;
      rest_q <= rest_d;
      wd3_q  <= wd2_q;
    end
  end

  assign year_o    = year_q;
  assign leap_o    = leap_q;
  assign rest_o    = rest_q;
  assign weekday_o = wd3_q;

endmodule

[rtl/esc_tod_split.sv]
// esc_tod_split: seconds of the day into hour, minute and second
// uses esc_pkg
module esc_tod_split (
  input  logic              clk_i,
  input  esc_pkg::esc_load_t load_i,
  input  logic [16:0]       tod_i,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o
);
  import esc_pkg::*;

  logic [10:0] mins_q, mins_d;
  logic [5:0]  sec2_q, sec2_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  sec3_q;

  logic [30:0] min_prod;
  logic [16:0] sec_full;
  logic [18:0] hour_prod;
  logic [10:0] minute_full;

  // stage b: minutes of the day and seconds
  always_comb begin
    min_prod = 31'(tod_i[16:2]) * 31'(MIN_RECIP);
    mins_d   = min_prod[MIN_SHIFT+10:MIN_SHIFT];
    sec_full = tod_i - 17'(mins_d) * 17'd60;
    sec2_d   = sec_full[5:0];
  end

  // stage c: hours and minutes
  always_comb begin
    hour_prod   = 19'(mins_q[10:2]) * 19'(HOUR_RECIP);
    hour_d      = hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
    minute_full = mins_q - 11'(hour_d) * 11'd60;
    minute_d    = minute_full[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load2) begin
      mins_q <= mins_d;
      sec2_q <= sec2_d;
    end
    if (load_i.load3) begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      sec3_q   <= sec2_q;
    end
  end

  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = sec3_q;

endmodule

[rtl/esc_month_find.sv]
// esc_month_find: month and day of month from the day of year, and the
// result register for every field; uses esc_pkg
module esc_month_find (
  input  logic              clk_i,
  input  esc_pkg::esc_load_t load_i,
  input  logic [11:0]       year_i,
  input  logic              leap_i,
  input  logic [8:0]        rest_i,
  input  logic [4:0]        hour_i,
  input  logic [5:0]        minute_i,
  input  logic [5:0]        second_i,
  input  logic [2:0]        weekday_i,
  output logic [11:0]       year_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_of_month_o,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o,
  output logic [2:0]        day_of_week_o,
  output logic [8:0]        day_of_year_o
);
  import esc_pkg::*;

  logic [11:0] year_q;
  logic [3:0]  month_q, month_d;
  logic [4:0]  dom_q, dom_d;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [2:0]  dow_q;
  logic [8:0]  doy_q;

  logic [3:0]  mon_idx;
  logic [8:0]  dom_full;

  // count month boundaries passed, each compare independent
  always_comb begin
    mon_idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (rest_i >= month_start(4'(m), leap_i)) begin
        mon_idx = mon_idx + 4'd1;
      end
    end
    month_d  = mon_idx + 4'd1;
    dom_full = rest_i - month_start(mon_idx, leap_i) + 9'd1;
    dom_d    = dom_full[4:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load_out) begin
      year_q   <= year_i;
      month_q  <= month_d;
      dom_q    <= dom_d;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      second_q <= second_i;
      dow_q    <= weekday_i;
      doy_q    <= rest_i;
    end
  end

  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;
  assign hour_o         = hour_q;
  assign minute_o       = minute_q;
  assign second_o       = second_q;
  assign day_of_week_o  = dow_q;
  assign day_of_year_o  = doy_q;

endmodule

[rtl/epoch_seconds_to_calendar_core.sv]
// epoch_seconds_to_calendar_core: unix seconds to broken-down utc calendar
// top level with pipeline control; uses esc_pkg and the esc_* stage modules
//
//   channel  direction  handshake                  payload
//   in       request    in_valid_i / in_stall_o    epoch_seconds_i
//   out      result     out_valid_o / out_stall_i  year_o .. day_of_year_o
//
// one request accepted per cycle while in_stall_o is low
// five register stages: input, day split, estimates, year and clock, result
// reset clears the stage valid flags only
// a stall on the output holds the result; earlier stages keep filling
// until every stage is full, then in_stall_o rises in the same cycle
module epoch_seconds_to_calendar_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [2:0]  day_of_week_o,
  output logic [8:0]  day_of_year_o
);
  import esc_pkg::*;

  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;
  esc_load_t load;

  logic [15:0] days;
  logic [16:0] tod;
  logic [11:0] year;
  logic        leap;
  logic [8:0]  rest;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  always_comb begin
    rdy_out       = !vo_q || !out_stall_i;
    rdy3          = !v3_q || rdy_out;
    rdy2          = !v2_q || rdy3;
    rdy1          = !v1_q || rdy2;
    rdy0          = !v0_q || rdy1;
    load.load0    = rdy0 && in_valid_i;
    load.load1    = rdy1 && v0_q;
    load.load2    = rdy2 && v1_q;
    load.load3    = rdy3 && v2_q;
    load.load_out = rdy_out && v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_out) begin
        vo_q <= v3_q;
      end
    end
  end

  assign in_stall_o  = !rdy0;
  assign out_valid_o = vo_q;

  esc_day_split u_day_split (
    .clk_i           (clk_i),
    .load_i          (load),
    .epoch_seconds_i (epoch_seconds_i),
    .days_o          (days),
    .tod_o           (tod)
  );

  esc_year_find u_year_find (
    .clk_i     (clk_i),
    .load_i    (load),
    .days_i    (days),
    .year_o    (year),
    .leap_o    (leap),
    .rest_o    (rest),
    .weekday_o (weekday)
  );

  esc_tod_split u_tod_split (
    .clk_i    (clk_i),
    .load_i   (load),
    .tod_i    (tod),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  esc_month_find u_month_find (
    .clk_i          (clk_i),
    .load_i         (load),
    .year_i         (year),
    .leap_i         (leap),
    .rest_i         (rest),
    .hour_i         (hour),
    .minute_i       (minute),
    .second_i       (second),
    .weekday_i      (weekday),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .day_of_week_o  (day_of_week_o),
    .day_of_year_o  (day_of_year_o)
  );

endmodule
